FILE: rtl/bmph_pkg.sv
package bmph_pkg;

    // One input beat: one bar's intensity
    typedef struct packed {
        logic [3:0] bar_index;
        logic [7:0] level;
    } item_t;

    // One output beat: one pixel of a bar column
    typedef struct packed {
        logic [3:0] column;
        logic [3:0] row;
        logic [1:0] pixel_kind;
        logic [7:0] palette_index;
        logic       last_row;
    } pixel_t;

    // Pixel kinds
    localparam logic [1:0] KIND_BLACK   = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_WHITE   = 2'd2;

    // Configuration register indexes
    typedef enum logic {
        CFG_DISPLAY_MODE = 1'b0,
        CFG_DECAY_PERIOD = 1'b1
    } cfg_index_t;

    localparam logic       DISPLAY_MODE_RESET = 1'b0;
    localparam logic [7:0] DECAY_PERIOD_RESET = 8'd4;

    // Rounded divide by 510 as multiply and shift; exact for numerators below 2^16
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_510   = ((2 ** RECIP_SHIFT) + 509) / 510;

    // Entries in the command queue between front and back
    localparam int CMDQ_DEPTH = 2;

endpackage

FILE: rtl/bmph_front.sv
module bmph_front #(
    parameter int BAR_COUNT  = 16,
    parameter int BAR_HEIGHT = 16,
    parameter int CMD_W      = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  bmph_pkg::item_t      item,
    input  logic                 display_mode,
    input  logic [7:0]           decay_period,
    output logic                 q_push,
    output logic [CMD_W-1:0]     q_data,
    input  logic                 q_full
);

    localparam int RW = $clog2(BAR_HEIGHT);
    localparam int HW = $clog2(BAR_HEIGHT + 1);
    localparam int PD = (BAR_COUNT < 16) ? BAR_COUNT : 16;
    localparam int IW = $clog2(PD);
    localparam int K1 = 2 * BAR_HEIGHT * bmph_pkg::RECIP_510;
    localparam int K2 = 255 * bmph_pkg::RECIP_510;

    typedef struct packed {
        logic [3:0]    bar;
        logic          mode;
        logic [7:0]    pal;
        logic [RW-1:0] h;
        logic [RW-1:0] peak;
    } cmd_t;

    logic          a_valid_reg, a_valid_next;
    logic [3:0]    a_bar_reg;
    logic [HW-1:0] a_hraw_reg;
    logic [31:0]   prod;
    logic          accept, in_range, b_go;

    logic [RW-1:0] peak_reg [PD];
    logic [7:0]    frame_phase_reg, frame_phase_next;

    logic [7:0]    bar_pal_tab  [PD];
    logic [7:0]    peak_pal_tab [BAR_HEIGHT];

    logic [IW-1:0] idx;
    logic [RW-1:0] h, peak_old, peak_new, peak_decayed;
    logic          last_bar;
    logic [7:0]    period;
    logic [8:0]    phase_inc;
    cmd_t          cmd;

    // Build palette tables from constants
    for (genvar g = 0; g < PD; g++) begin : g_bar_pal
        localparam int PAL = (2 * g * 255 + BAR_COUNT) / (2 * BAR_COUNT);
        assign bar_pal_tab[g] = 8'(PAL);
    end
    for (genvar g = 0; g < BAR_HEIGHT; g++) begin : g_peak_pal
        localparam int PAL = (2 * g * 255 + BAR_HEIGHT) / (2 * BAR_HEIGHT);
        assign peak_pal_tab[g] = 8'(PAL);
    end

    // Stage A: accept, drop out-of-range bars, scale level to a raw height
    assign in_range   = 7'(item.bar_index) < 7'(BAR_COUNT);
    assign b_go       = a_valid_reg && !q_full;
    assign item_stall = a_valid_reg && !b_go;
    assign accept     = item_valid && !item_stall;
    assign prod       = 32'(item.level) * 32'(K1) + 32'(K2);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = in_range;
        end
        else if (b_go)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_bar_reg  <= item.bar_index;
            a_hraw_reg <= prod[bmph_pkg::RECIP_SHIFT +: HW];
        end
    end

    // Stage B: clamp, raise peak, pick palette, decay, build command
    assign idx      = a_bar_reg[IW-1:0];
    assign h        = (a_hraw_reg > HW'(BAR_HEIGHT - 1)) ? RW'(BAR_HEIGHT - 1)
                                                         : a_hraw_reg[RW-1:0];
    assign peak_old = peak_reg[idx];
    assign peak_new = (h > peak_old) ? h : peak_old;
    assign peak_decayed = (frame_phase_reg == 8'd0 && peak_new != '0)
                          ? peak_new - RW'(1) : peak_new;
    assign last_bar = 7'(a_bar_reg) == 7'(BAR_COUNT - 1);

    assign period    = (decay_period == 8'd0) ? 8'd1 : decay_period;
    assign phase_inc = {1'b0, frame_phase_reg} + 9'd1;

    always_comb
    begin
        frame_phase_next = frame_phase_reg;
        if (b_go && last_bar)
        begin
            frame_phase_next = (phase_inc >= {1'b0, period}) ? 8'd0 : phase_inc[7:0];
        end
    end

    always_comb
    begin
        cmd.bar  = a_bar_reg;
        cmd.mode = display_mode;
        cmd.pal  = display_mode ? peak_pal_tab[peak_new] : bar_pal_tab[idx];
        cmd.h    = h;
        cmd.peak = peak_new;
    end

    assign q_push = b_go;
    assign q_data = cmd;

    // Commit peak and frame phase when the command enters the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PD; i++)
            begin
                peak_reg[i] <= '0;
            end
            frame_phase_reg <= 8'd0;
        end
        else
        begin
            if (b_go)
            begin
                peak_reg[idx] <= peak_decayed;
            end
            frame_phase_reg <= frame_phase_next;
        end
    end

endmodule

FILE: rtl/bmph_queue.sv
module bmph_queue #(
    parameter int WIDTH = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = bmph_pkg::CMDQ_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/bmph_back.sv
module bmph_back #(
    parameter int BAR_HEIGHT = 16,
    parameter int CMD_W      = 21
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [CMD_W-1:0]  q_data,
    output logic              pixel_valid,
    input  logic              pixel_stall,
    output bmph_pkg::pixel_t  pixel
);

    localparam int RW = $clog2(BAR_HEIGHT);

    typedef struct packed {
        logic [3:0]    bar;
        logic          mode;
        logic [7:0]    pal;
        logic [RW-1:0] h;
        logic [RW-1:0] peak;
    } cmd_t;

    cmd_t             cmd_reg;
    logic             busy_reg, busy_next;
    logic [RW-1:0]    row_reg, row_next;
    logic             out_valid_reg;
    bmph_pkg::pixel_t out_reg, pix;
    logic             adv, last, fetch;

    assign adv   = !out_valid_reg || !pixel_stall;
    assign last  = row_reg == RW'(BAR_HEIGHT - 1);
    assign fetch = q_valid && (!busy_reg || (adv && last));
    assign q_pop = fetch;

    // Sequence rows of the current bar; pick up the next bar on the last row
    always_comb
    begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (fetch)
        begin
            busy_next = 1'b1;
            row_next  = '0;
        end
        else if (busy_reg && adv)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + RW'(1);
            end
        end
    end

    // Shade one pixel
    always_comb
    begin
        pix.column        = cmd_reg.bar;
        pix.row           = 4'(row_reg);
        pix.last_row      = last;
        pix.pixel_kind    = bmph_pkg::KIND_BLACK;
        pix.palette_index = 8'd0;
        if (!cmd_reg.mode)
        begin
            if (row_reg == cmd_reg.peak)
            begin
                pix.pixel_kind = bmph_pkg::KIND_WHITE;
            end
            else if (row_reg < cmd_reg.h)
            begin
                pix.pixel_kind    = bmph_pkg::KIND_PALETTE;
                pix.palette_index = cmd_reg.pal;
            end
        end
        else if (row_reg == cmd_reg.peak)
        begin
            pix.pixel_kind    = bmph_pkg::KIND_PALETTE;
            pix.palette_index = cmd_reg.pal;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
            if (adv)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    // Hold command and output beat
    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            cmd_reg <= q_data;
        end
        if (adv && busy_reg)
        begin
            out_reg <= pix;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

endmodule

FILE: rtl/bar_meter_peak_hold_top.sv
// Bar meter with peak hold.
// Item channel (item_valid / item_stall / item): one beat per bar carries
// bar_index and an 8-bit level. A beat with a bar_index of BAR_COUNT or more
// is taken and dropped. Each kept beat yields BAR_HEIGHT pixel beats on the
// pixel channel (pixel_valid / pixel_stall / pixel), bottom row first, with
// last_row set on the top row.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// always ready; write only while no pixels are pending.
// The first pixel of a bar passes through the scale register, the peak
// update into the command queue, the row sequencer and the output
// register. Throughput: one pixel per cycle while pixel_stall is low,
// set by the single-pixel output of the row sequencer; the front keeps
// accepting items while the two-entry command queue has room.
// Reset clears all stored peaks, the frame phase and both registers
// (display_mode 0, decay_period 4). When pixel_stall is high the output beat
// holds, the row sequencer waits, the queue fills and then item_stall rises.
module bar_meter_peak_hold_top #(
    parameter int BAR_COUNT  = 16,
    parameter int BAR_HEIGHT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  bmph_pkg::item_t      item,
    output logic                 pixel_valid,
    input  logic                 pixel_stall,
    output bmph_pkg::pixel_t     pixel,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  bmph_pkg::cfg_index_t cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int RW    = $clog2(BAR_HEIGHT);
    localparam int CMD_W = 13 + 2 * RW;

    logic             display_mode_reg;
    logic [7:0]       decay_period_reg;
    logic             q_push, q_full, q_pop, q_valid;
    logic [CMD_W-1:0] q_wdata, q_rdata;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg <= bmph_pkg::DISPLAY_MODE_RESET;
            decay_period_reg <= bmph_pkg::DECAY_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bmph_pkg::CFG_DISPLAY_MODE: display_mode_reg <= cfg_data[0];
                bmph_pkg::CFG_DECAY_PERIOD: decay_period_reg <= cfg_data;
                default:                    display_mode_reg <= display_mode_reg;
            endcase
        end
    end

    bmph_front #(
        .BAR_COUNT  (BAR_COUNT),
        .BAR_HEIGHT (BAR_HEIGHT),
        .CMD_W      (CMD_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .display_mode (display_mode_reg),
        .decay_period (decay_period_reg),
        .q_push       (q_push),
        .q_data       (q_wdata),
        .q_full       (q_full)
    );

    bmph_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    bmph_back #(
        .BAR_HEIGHT (BAR_HEIGHT),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_rdata),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

endmodule

FILE: bench/bar_meter_peak_hold_top_tb.sv
module bar_meter_peak_hold_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BARS          = 16;
    localparam int ROWS          = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 12;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int FRAMES_PER_PHASE = 4;

    typedef enum logic [1:0] {
        OP_ITEM = 2'd0,
        OP_CFG  = 2'd1,
        OP_HOLD = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        bmph_pkg::item_t      beat;
        bmph_pkg::cfg_index_t idx;
        logic [7:0]           data;
        logic [3:0]           gap;
    } stim_op_t;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid  = 1'b0;
    logic                 item_stall;
    bmph_pkg::item_t      item        = '0;
    logic                 pixel_valid;
    logic                 pixel_stall = 1'b0;
    bmph_pkg::pixel_t     pixel;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    bmph_pkg::cfg_index_t cfg_index   = bmph_pkg::CFG_DISPLAY_MODE;
    logic [7:0]           cfg_data    = 8'd0;

    // Shadow state of the meter
    logic [3:0] peak_model [BARS];
    logic [7:0] phase_model;
    logic       mode_model;
    logic [7:0] period_model;

    bmph_pkg::pixel_t pixel_expect_q [$];
    stim_op_t         stim_q [$];

    int         pixels_due  = 0;
    int         pixels_seen = 0;
    int         mismatches  = 0;
    int         cycles      = 0;
    logic       stim_done   = 1'b0;

    // Driver working state
    stim_op_t   cur_op;
    logic       have_op;
    int         wait_left;
    int         quiet_run;
    logic       next_item_valid;
    logic       next_cfg_valid;

    // Receiver working state
    int         rx_wait;
    int         rx_draw;
    logic       rx_calm;

    bar_meter_peak_hold_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Compute the pixels of one bar column, then apply decay and frame end
    task automatic shade_column(input bmph_pkg::item_t beat);
        int               bar;
        int               lvl;
        int               h;
        int               top;
        int               bar_pal;
        int               peak_pal;
        int               per;
        int               nxt;
        bmph_pkg::pixel_t px;
        bar = beat.bar_index;
        lvl = beat.level;
        h = (2 * lvl * ROWS + 255) / 510;
        if (h > ROWS - 1)
            h = ROWS - 1;
        if (h > peak_model[bar])
            peak_model[bar] = h[3:0];
        top      = peak_model[bar];
        bar_pal  = (2 * bar * 255 + BARS) / (2 * BARS);
        peak_pal = (2 * top * 255 + ROWS) / (2 * ROWS);
        for (int r = 0; r < ROWS; r++)
        begin
            px.column        = bar[3:0];
            px.row           = r[3:0];
            px.pixel_kind    = bmph_pkg::KIND_BLACK;
            px.palette_index = 8'd0;
            px.last_row      = (r == ROWS - 1);
            if (mode_model == 1'b0)
            begin
                if (r == top)
                    px.pixel_kind = bmph_pkg::KIND_WHITE;
                else if (r < h)
                begin
                    px.pixel_kind    = bmph_pkg::KIND_PALETTE;
                    px.palette_index = bar_pal[7:0];
                end
            end
            else if (r == top)
            begin
                px.pixel_kind    = bmph_pkg::KIND_PALETTE;
                px.palette_index = peak_pal[7:0];
            end
            pixel_expect_q.push_back(px);
        end
        if (phase_model == 8'd0 && peak_model[bar] > 0)
            peak_model[bar] = peak_model[bar] - 4'd1;
        if (bar == BARS - 1)
        begin
            per = (period_model == 8'd0) ? 1 : period_model;
            nxt = phase_model + 1;
            phase_model = (nxt >= per) ? 8'd0 : nxt[7:0];
        end
    endtask

    // Driver: present items and register writes from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            cfg_valid  <= 1'b0;
            have_op    = 1'b0;
            wait_left  = 0;
            quiet_run  = 0;
            stim_done  <= 1'b0;
            for (int i = 0; i < BARS; i++)
                peak_model[i] = 4'd0;
            phase_model  = 8'd0;
            mode_model   = bmph_pkg::DISPLAY_MODE_RESET;
            period_model = bmph_pkg::DECAY_PERIOD_RESET;
        end
        else
        begin
            next_item_valid = item_valid;
            next_cfg_valid  = cfg_valid;
            if (item_valid && !item_stall)
            begin
                shade_column(item);
                pixels_due <= pixels_due + ROWS;
                next_item_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bmph_pkg::CFG_DISPLAY_MODE)
                    mode_model = cfg_data[0];
                else
                    period_model = cfg_data;
                next_cfg_valid = 1'b0;
            end
            if (!next_item_valid && !next_cfg_valid)
            begin
                if (!have_op && stim_q.size() > 0)
                begin
                    cur_op    = stim_q.pop_front();
                    have_op   = 1'b1;
                    wait_left = cur_op.gap;
                    quiet_run = 0;
                end
                if (have_op)
                begin
                    if (cur_op.kind == OP_ITEM)
                    begin
                        if (wait_left > 0)
                            wait_left--;
                        else
                        begin
                            item <= cur_op.beat;
                            next_item_valid = 1'b1;
                            have_op = 1'b0;
                        end
                    end
                    else
                    begin
                        // Hold until the pixel stream has drained and settled
                        if (pixels_seen < pixels_due)
                            quiet_run = 0;
                        else if (quiet_run < SETTLE_CYCLES)
                            quiet_run++;
                        else
                        begin
                            if (cur_op.kind == OP_CFG)
                            begin
                                cfg_index <= cur_op.idx;
                                cfg_data  <= cur_op.data;
                                next_cfg_valid = 1'b1;
                            end
                            have_op = 1'b0;
                        end
                    end
                end
            end
            item_valid <= next_item_valid;
            cfg_valid  <= next_cfg_valid;
            stim_done  <= (stim_q.size() == 0) && !have_op &&
                          !next_item_valid && !next_cfg_valid;
        end
    end

    // Monitor: stall at random and compare each pixel beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_stall <= 1'b0;
            rx_wait     = 0;
            rx_calm     = 1'b0;
        end
        else
        begin
            rx_draw = rx_wait;
            if (pixel_valid && !pixel_stall)
            begin
                pixels_seen <= pixels_seen + 1;
                if (pixel_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected pixel beat: col %0d row %0d kind %0d pal %0d last %0b",
                                 pixel.column, pixel.row, pixel.pixel_kind,
                                 pixel.palette_index, pixel.last_row);
                end
                else
                begin
                    bmph_pkg::pixel_t want;
                    want = pixel_expect_q.pop_front();
                    if (pixel.column !== want.column || pixel.row !== want.row ||
                        pixel.pixel_kind !== want.pixel_kind ||
                        pixel.palette_index !== want.palette_index ||
                        pixel.last_row !== want.last_row)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("pixel mismatch: expected col %0d row %0d kind %0d pal %0d last %0b",
                                     want.column, want.row, want.pixel_kind,
                                     want.palette_index, want.last_row);
                            $display("                got col %0d row %0d kind %0d pal %0d last %0b",
                                     pixel.column, pixel.row, pixel.pixel_kind,
                                     pixel.palette_index, pixel.last_row);
                        end
                    end
                end
                if ($urandom_range(0, 47) == 0)
                    rx_calm = !rx_calm;
                rx_draw = rx_calm ? 0 : $urandom_range(0, 13);
            end
            if (rx_draw > 0)
            begin
                pixel_stall <= 1'b1;
                rx_wait = rx_draw - 1;
            end
            else
            begin
                pixel_stall <= 1'b0;
                rx_wait = 0;
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_item(input logic [3:0] bar, input logic [7:0] lvl, input int gap);
        stim_op_t op;
        op = '0;
        op.kind           = OP_ITEM;
        op.beat.bar_index = bar;
        op.beat.level     = lvl;
        op.gap            = gap[3:0];
        stim_q.push_back(op);
    endtask

    task automatic push_cfg(input bmph_pkg::cfg_index_t idx, input logic [7:0] data);
        stim_op_t op;
        op = '0;
        op.kind = OP_CFG;
        op.idx  = idx;
        op.data = data;
        stim_q.push_back(op);
    endtask

    task automatic push_hold();
        stim_op_t op;
        op = '0;
        op.kind = OP_HOLD;
        stim_q.push_back(op);
    endtask

    function automatic logic [7:0] pick_level();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'd0;
        if (sel == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one frame: mostly in bar order, sometimes broken or partial
    task automatic push_frame();
        int   shape;
        int   first;
        int   count;
        logic calm;
        calm  = ($urandom_range(0, 3) == 0);
        shape = $urandom_range(0, 9);
        first = 0;
        count = BARS;
        if (shape == 8)
            count = $urandom_range(1, BARS - 1);
        else if (shape == 9)
        begin
            first = $urandom_range(1, BARS - 1);
            count = BARS - first;
        end
        for (int i = 0; i < count; i++)
        begin
            if (shape == 7)
                push_item(4'($urandom_range(0, BARS - 1)), pick_level(),
                          calm ? 0 : $urandom_range(0, 13));
            else
                push_item(4'(first + i), pick_level(), calm ? 0 : $urandom_range(0, 13));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;

        // Directed: level extremes and rounding edges in bars mode
        push_item(4'd0, 8'd0, 0);
        push_item(4'd0, 8'd255, 0);
        push_item(4'd0, 8'd0, 3);
        push_item(4'd1, 8'd8, 0);
        push_item(4'd1, 8'd7, 0);
        push_item(4'd2, 8'd231, 1);
        push_item(4'd3, 8'd239, 0);
        push_item(4'd4, 8'd128, 0);
        push_item(4'd15, 8'd255, 0);
        push_item(4'd15, 8'd0, 2);
        // Repeat a bar within one frame
        push_item(4'd0, 8'd100, 0);
        push_item(4'd0, 8'd100, 0);
        // Peak dot mode
        push_cfg(bmph_pkg::CFG_DISPLAY_MODE, 8'h01);
        push_item(4'd5, 8'd255, 0);
        push_item(4'd5, 8'd0, 0);
        push_item(4'd6, 8'd0, 0);
        push_item(4'd15, 8'd64, 0);
        // Zero decay period behaves as one
        push_cfg(bmph_pkg::CFG_DECAY_PERIOD, 8'd0);
        push_item(4'd15, 8'd200, 0);
        push_item(4'd15, 8'd0, 0);
        push_item(4'd7, 8'd255, 0);
        // Phase beyond a lowered period wraps at the next frame end
        push_cfg(bmph_pkg::CFG_DISPLAY_MODE, 8'hFE);
        push_cfg(bmph_pkg::CFG_DECAY_PERIOD, 8'd255);
        for (int i = 0; i < 6; i++)
            push_item(4'd15, 8'(40 * i), 0);
        push_cfg(bmph_pkg::CFG_DECAY_PERIOD, 8'd2);
        push_item(4'd15, 8'd30, 0);
        push_item(4'd9, 8'd90, 0);

        // Random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            push_cfg(bmph_pkg::CFG_DISPLAY_MODE, 8'($urandom_range(0, 255)));
            case (p)
                0: push_cfg(bmph_pkg::CFG_DECAY_PERIOD, 8'd1);
                1: push_cfg(bmph_pkg::CFG_DECAY_PERIOD, 8'd255);
                2: push_cfg(bmph_pkg::CFG_DECAY_PERIOD, 8'd0);
                3: push_cfg(bmph_pkg::CFG_DECAY_PERIOD, 8'd2);
                default: push_cfg(bmph_pkg::CFG_DECAY_PERIOD, 8'($urandom_range(0, 255)));
            endcase
            for (int f = 0; f < FRAMES_PER_PHASE; f++)
            begin
                if (p == RANDOM_PHASES / 2 && f == FRAMES_PER_PHASE / 2)
                    push_hold();
                push_frame();
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain and settle
        do
            @(posedge clk);
        while (!(stim_done && pixels_seen >= pixels_due));
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        mismatches += pixel_expect_q.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
